// ===== sv/binary_input_report_throttle_top_defines.svh =====
// ----------------------------------------------------------------------------
// binary input report throttle assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef BINARY_INPUT_REPORT_THROTTLE_TOP_DEFINES_SVH
`define BINARY_INPUT_REPORT_THROTTLE_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define BITR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BITR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bitr_pkg.sv =====
// ----------------------------------------------------------------------------
// binary input report throttle package
// widths, codes and record types of the report throttle
// ----------------------------------------------------------------------------
package bitr_pkg;

  localparam int TW = 32;

  typedef enum logic [1:0] {
    ACT_TICK       = 2'd0,
    ACT_UPDATE     = 2'd1,
    ACT_REVALIDATE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    KIND_VALUE      = 2'd0,
    KIND_INVALIDATE = 2'd1,
    KIND_DEFERRED   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_AUTO_RESET_VALUE      = 3'd0,
    REG_AUTO_RESET_DELAY      = 3'd1,
    REG_ALIVE_INTERVAL        = 3'd2,
    REG_MIN_PUSH_INTERVAL     = 3'd3,
    REG_CHANGES_ONLY_INTERVAL = 3'd4,
    REG_MAX_PUSH_INTERVAL     = 3'd5,
    REG_TRI_STATE_MODE        = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] value;
    logic       defined;
    logic       changed;
    logic       done;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]    cur;
    logic          defined;
    logic [TW-1:0] since_push;
    logic          ever_pushed;
    logic [TW-1:0] to_left;
    logic          to_armed;
    logic [2:0]    to_target;
    logic [TW-1:0] pt_left;
    logic          pt_armed;
    logic          pt_final;
  } core_t;

  typedef struct packed {
    core_t      st;
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
    logic       touched;
  } work_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

endpackage

// ===== sv/binary_input_report_throttle_top.sv =====
// a request passes the input register and the result queue on its way to the result port
// throughput: one request per cycle while the two-entry result queue has room;
// a request with two reports holds the result port until both are taken
// reset: synchronous, clears the tracked input, timers and queue and loads
// the register defaults; no clearing pass
// ----------------------------------------------------------------------------
// binary input report throttle
// tracks a binary or tri-state input and decides when its value is pushed
// ----------------------------------------------------------------------------
`include "binary_input_report_throttle_top_defines.svh"

module binary_input_report_throttle_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [bitr_pkg::TW-1:0]  cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               action,
  input  logic [1:0]               new_state,
  input  logic                     push_accepted,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               report_kind,
  output logic [1:0]               reported_value,
  output logic                     value_defined,
  output logic                     state_changed,
  output logic                     push_done,
  output logic                     last_report
);

  // configuration registers
  logic [2:0]               ar_value;
  logic [bitr_pkg::TW-1:0]  ar_delay;
  logic [bitr_pkg::TW-1:0]  alive_ivl;
  logic [bitr_pkg::TW-1:0]  min_push;
  logic [bitr_pkg::TW-1:0]  chg_ivl;
  logic [bitr_pkg::TW-1:0]  max_push;
  logic                     tri_mode;

  // input register
  logic       s_valid;
  logic [1:0] s_action;
  logic [1:0] s_new;
  logic       s_acc;

  bitr_pkg::core_t  core;
  bitr_pkg::core_t  core_next;
  bitr_pkg::work_t  w;
  logic             t_fire;
  logic             p_fire;

  // result queue
  bitr_pkg::entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       sub;
  logic       room;
  logic       proc;
  logic       push;
  logic       pop;
  bitr_pkg::entry_t head;
  bitr_pkg::res_t   res;

  function automatic bitr_pkg::work_t f_emit(bitr_pkg::work_t wi, bitr_pkg::kind_t kind,
                                              logic ch, logic done);
    bitr_pkg::work_t wo;
    bitr_pkg::res_t  r;
    wo = wi;
    r.kind    = kind;
    r.value   = wi.st.cur;
    r.defined = wi.st.defined;
    r.changed = ch;
    r.done    = done;
    r.last    = 1'b0;
    if (wo.n == 2'd0) begin
      wo.r0 = r;
    end else if (wo.n == 2'd1) begin
      wo.r1 = r;
    end
    if (wo.n != 2'd2) begin
      wo.n = wo.n + 2'd1;
    end
    return wo;
  endfunction

  function automatic bitr_pkg::work_t f_arm_timeout(bitr_pkg::work_t wi,
                                                     logic [bitr_pkg::TW-1:0] delay,
                                                     logic [2:0] target);
    bitr_pkg::work_t wo;
    wo = wi;
    if (delay == '0) begin
      wo.st.to_armed = 1'b0;
      wo.st.to_left  = '0;
    end else begin
      wo.st.to_armed  = 1'b1;
      wo.st.to_left   = delay;
      wo.st.to_target = target;
    end
    return wo;
  endfunction

  function automatic bitr_pkg::work_t f_push_value(bitr_pkg::work_t wi, logic ch, logic acc);
    bitr_pkg::work_t wo;
    wo = wi;
    if (!wo.st.ever_pushed || (wo.st.since_push > min_push)) begin
      if (acc) begin
        wo.st.since_push  = '0;
        wo.st.ever_pushed = 1'b1;
        // periodic re-push after a good push of a defined value
        if (wo.st.defined && (max_push != '0)) begin
          wo.st.pt_armed = 1'b1;
          wo.st.pt_left  = max_push;
          wo.st.pt_final = 1'b0;
          wo.touched     = 1'b1;
        end
      end
      wo = f_emit(wo, bitr_pkg::KIND_VALUE, ch, acc);
    end else if (ch) begin
      // too early: defer the change until the gap has passed
      wo.st.pt_armed = 1'b1;
      wo.st.pt_left  = min_push - wo.st.since_push;
      wo.st.pt_final = 1'b1;
      wo.touched     = 1'b1;
      wo = f_emit(wo, bitr_pkg::KIND_DEFERRED, 1'b1, 1'b0);
    end
    return wo;
  endfunction

  function automatic bitr_pkg::work_t f_update(bitr_pkg::work_t wi, logic [1:0] s_in,
                                                logic acc);
    bitr_pkg::work_t wo;
    logic [1:0]      maxv;
    logic [1:0]      s;
    logic            ch;
    wo   = wi;
    maxv = tri_mode ? 2'd2 : 2'd1;
    s    = (s_in > maxv) ? maxv : s_in;
    wo.st.defined = 1'b1;
    if (!ar_value[2] && (ar_value[1:0] != s)) begin
      wo = f_arm_timeout(wo, ar_delay, ar_value);
    end else begin
      wo = f_arm_timeout(wo, alive_ivl, 3'b111);
    end
    ch = (s != wo.st.cur);
    if (ch || !wo.st.ever_pushed || (wo.st.since_push > chg_ivl)) begin
      wo.st.cur = s;
      wo = f_push_value(wo, ch, acc);
    end
    return wo;
  endfunction

  function automatic bitr_pkg::work_t f_invalidate(bitr_pkg::work_t wi, logic acc);
    bitr_pkg::work_t wo;
    wo = wi;
    if (wo.st.defined) begin
      wo.st.defined  = 1'b0;
      wo.st.pt_armed = 1'b0;
      wo.st.pt_left  = '0;
      wo.touched     = 1'b1;
      if (acc) begin
        wo.st.since_push  = '0;
        wo.st.ever_pushed = 1'b1;
      end
      wo = f_emit(wo, bitr_pkg::KIND_INVALIDATE, 1'b0, acc);
    end
    return wo;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ar_value  <= 3'b111;
      ar_delay  <= bitr_pkg::TW'(15000);
      alive_ivl <= '0;
      min_push  <= bitr_pkg::TW'(2000);
      chg_ivl   <= bitr_pkg::TW'(1800000);
      max_push  <= '0;
      tri_mode  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bitr_pkg::REG_AUTO_RESET_VALUE:      ar_value  <= cfg_data[2:0];
        bitr_pkg::REG_AUTO_RESET_DELAY:      ar_delay  <= cfg_data;
        bitr_pkg::REG_ALIVE_INTERVAL:        alive_ivl <= cfg_data;
        bitr_pkg::REG_MIN_PUSH_INTERVAL:     min_push  <= cfg_data;
        bitr_pkg::REG_CHANGES_ONLY_INTERVAL: chg_ivl   <= cfg_data;
        bitr_pkg::REG_MAX_PUSH_INTERVAL:     max_push  <= cfg_data;
        bitr_pkg::REG_TRI_STATE_MODE:        tri_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign room     = (cnt != 2'd2) || pop;
  assign proc     = s_valid && room;
  assign in_ready = !s_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_action <= action;
      s_new    <= new_state;
      s_acc    <= push_accepted;
    end
  end

  always_comb begin
    w         = '0;
    w.st      = core;
    t_fire    = 1'b0;
    p_fire    = 1'b0;
    if (s_action == bitr_pkg::ACT_TICK) begin
      if (w.st.since_push != '1) begin
        w.st.since_push = w.st.since_push + bitr_pkg::TW'(1);
      end
      if (w.st.to_armed) begin
        if (w.st.to_left <= bitr_pkg::TW'(1)) begin
          t_fire       = 1'b1;
          w.st.to_left = '0;
        end else begin
          w.st.to_left = w.st.to_left - bitr_pkg::TW'(1);
        end
      end
      if (w.st.pt_armed) begin
        if (w.st.pt_left <= bitr_pkg::TW'(1)) begin
          p_fire       = 1'b1;
          w.st.pt_left = '0;
        end else begin
          w.st.pt_left = w.st.pt_left - bitr_pkg::TW'(1);
        end
      end
    end
    if (t_fire) begin
      w.st.to_armed = 1'b0;
      if (w.st.to_target[2]) begin
        w = f_invalidate(w, s_acc);
      end else begin
        w = f_update(w, w.st.to_target[1:0], s_acc);
      end
    end
    if (s_action == bitr_pkg::ACT_UPDATE) begin
      w = f_update(w, s_new, s_acc);
    end
    // push timer is skipped when the timeout or update action re-armed or cancelled it
    if (p_fire && !w.touched && w.st.pt_armed) begin
      if (w.st.pt_final) begin
        w.st.pt_armed = 1'b0;
        w.st.pt_left  = '0;
        w.touched     = 1'b1;
        if (s_acc) begin
          w.st.since_push  = '0;
          w.st.ever_pushed = 1'b1;
        end
        w = f_emit(w, bitr_pkg::KIND_VALUE, 1'b1, s_acc);
      end else begin
        w.st.pt_armed = 1'b0;
        w = f_push_value(w, 1'b0, s_acc);
      end
    end
    if (s_action == bitr_pkg::ACT_REVALIDATE) begin
      if (w.st.defined && (ar_value[2] || (ar_delay == '0) ||
          (ar_value[1:0] == w.st.cur))) begin
        w = f_arm_timeout(w, alive_ivl, 3'b111);
      end
    end
    if (w.n == 2'd2) begin
      w.r1.last = 1'b1;
    end else if (w.n == 2'd1) begin
      w.r0.last = 1'b1;
    end
    core_next = proc ? w.st : core;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      core <= '{to_target: 3'b111, default: '0};
    end else begin
      core <= core_next;
    end
  end

  assign push = proc && (w.n != 2'd0);
  assign head = mem[rd_ptr];
  assign res  = sub ? head.r1 : head.r0;
  assign pop  = out_valid && out_ready && res.last;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{two: (w.n == 2'd2), r0: w.r0, r1: w.r1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
      sub    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (out_valid && out_ready) begin
        if (res.last) begin
          rd_ptr <= ~rd_ptr;
          sub    <= 1'b0;
        end else begin
          sub    <= 1'b1;
        end
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid      = (cnt != 2'd0);
  assign report_kind    = res.kind;
  assign reported_value = res.value;
  assign value_defined  = res.defined;
  assign state_changed  = res.changed;
  assign push_done      = res.done;
  assign last_report    = res.last;

  `BITR_ASSERT_NOW(a_defer_not_done,
    out_valid && (report_kind == bitr_pkg::KIND_DEFERRED),
    !push_done && state_changed, "deferral marked done or unchanged")
  `BITR_ASSERT_NOW(a_inval_undef,
    out_valid && (report_kind == bitr_pkg::KIND_INVALIDATE),
    !value_defined, "invalidation with defined value")
  `BITR_ASSERT_NOW(a_final_after_push,
    core.pt_armed && core.pt_final,
    core.ever_pushed, "deferred push armed before any push")
  `BITR_ASSERT_NEXT(a_second_half,
    out_valid && out_ready && !last_report,
    out_valid && sub && head.two, "second report of a request missing")
  `BITR_ASSERT_NOW(a_queue_room,
    push && !pop,
    cnt != 2'd2, "result queue overflow")

endmodule
